FILE: hw/rtl/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and constants for the bitmap block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int unsigned ADDR_W          = 32;
  localparam int unsigned BSIZE_W         = 17;
  localparam int unsigned DEF_NUM_BLOCKS  = 64;

  localparam logic [ADDR_W-1:0]  BASE_RESET  = '0;
  localparam logic [BSIZE_W-1:0] BSIZE_RESET = 17'd16;

  // config register indexes
  localparam logic CFG_BASE_ADDRESS = 1'b0;
  localparam logic CFG_BLOCK_SIZE   = 1'b1;

  typedef enum logic [1:0] {
    CMD_ALLOC    = 2'd0,
    CMD_FREE     = 2'd1,
    CMD_CONTAINS = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_EXHAUSTED  = 3'd1,
    ST_MISALIGNED = 3'd2,
    ST_DOUBLE     = 3'd3,
    ST_RANGE      = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_OFFSET,
    S_DIV,
    S_CHECK,
    S_DONE
  } state_e;

  typedef enum logic [1:0] {
    MAP_NONE,
    MAP_SET,
    MAP_CLR
  } map_op_e;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_e;

  typedef struct packed {
    logic [ADDR_W-1:0] block_address;
    logic              hit;
    status_e           status;
  } result_t;

endpackage

FILE: hw/rtl/bba_addsub.sv
// ----------------------------------------------------------------------------
// bba_addsub
// Shared 32-bit add/subtract unit. Bit 32 is the carry on add and the
// borrow on subtract.
// ----------------------------------------------------------------------------
module bba_addsub
  import bba_pkg::*;
(
  input  logic [ADDR_W-1:0] a_i,
  input  logic [ADDR_W-1:0] b_i,
  input  alu_op_e           op_i,
  output logic [ADDR_W:0]   res_o
);

  always_comb begin
    unique case (op_i)
      ALU_ADD: res_o = {1'b0, a_i} + {1'b0, b_i};
      ALU_SUB: res_o = {1'b0, a_i} - {1'b0, b_i};
      default: res_o = '0;
    endcase
  end

endmodule

FILE: hw/rtl/bba_seq.sv
// ----------------------------------------------------------------------------
// bba_seq
// Command sequencer: bit scan for allocate, offset and restoring division
// for free / contains, all on one shared add/subtract unit.
// ----------------------------------------------------------------------------
module bba_seq
  import bba_pkg::*;
#(
  parameter int unsigned NUM_BLOCKS = DEF_NUM_BLOCKS,
  parameter int unsigned IDX_W      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            in_cmd_i,
  input  logic [ADDR_W-1:0]     in_addr_i,
  input  logic [ADDR_W-1:0]     base_i,
  input  logic [BSIZE_W-1:0]    bsize_i,     // already forced nonzero
  input  logic [NUM_BLOCKS-1:0] free_map_i,
  output logic                  done_o,
  input  logic                  ack_i,
  output result_t               res_o,
  output map_op_e               map_op_o,
  output logic [IDX_W-1:0]      map_idx_o
);

  localparam int unsigned CNT_W = $clog2(ADDR_W);
  localparam logic [CNT_W-1:0]  CNT_LAST  = CNT_W'(ADDR_W - 1);
  localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(NUM_BLOCKS - 1);
  localparam logic [ADDR_W-1:0] POOL_LIM  = ADDR_W'(NUM_BLOCKS);

  state_e              state_q, state_d;
  logic [1:0]          cmd_q, cmd_d;
  logic [ADDR_W-1:0]   addr_q, addr_d;
  logic [ADDR_W-1:0]   acc_q, acc_d;       // scan address / quotient
  logic [BSIZE_W-1:0]  rem_q, rem_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  result_t             res_q, res_d;
  map_op_e             map_op_q, map_op_d;
  logic [IDX_W-1:0]    map_idx_q, map_idx_d;

  logic [ADDR_W-1:0]   alu_a, alu_b;
  alu_op_e             alu_op;
  logic [ADDR_W:0]     alu_res;
  logic [BSIZE_W:0]    rem_shift;
  logic                in_pool;

  bba_addsub u_addsub (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .op_i  (alu_op),
    .res_o (alu_res)
  );

  assign rem_shift = {rem_q, acc_q[ADDR_W-1]};
  assign in_pool   = (acc_q < POOL_LIM);

  assign in_ready_o = (state_q == S_IDLE);
  assign done_o     = (state_q == S_DONE);
  assign res_o      = res_q;
  assign map_op_o   = map_op_q;
  assign map_idx_o  = map_idx_q;

  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    addr_d    = addr_q;
    acc_d     = acc_q;
    rem_d     = rem_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    res_d     = res_q;
    map_op_d  = map_op_q;
    map_idx_d = map_idx_q;
    alu_a     = '0;
    alu_b     = '0;
    alu_op    = ALU_ADD;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d    = in_cmd_i;
          addr_d   = in_addr_i;
          res_d    = '{block_address: '0, hit: 1'b0, status: ST_OK};
          map_op_d = MAP_NONE;
          unique case (in_cmd_i)
            CMD_ALLOC: begin
              acc_d   = base_i;
              idx_d   = '0;
              state_d = S_SCAN;
            end
            CMD_FREE, CMD_CONTAINS: state_d = S_OFFSET;
            default:                state_d = S_DONE;
          endcase
        end
      end

      S_SCAN: begin
        alu_a  = acc_q;
        alu_b  = ADDR_W'(bsize_i);
        alu_op = ALU_ADD;
        if (free_map_i[idx_q]) begin
          res_d     = '{block_address: acc_q, hit: 1'b1, status: ST_OK};
          map_op_d  = MAP_CLR;
          map_idx_d = idx_q;
          state_d   = S_DONE;
        end else if (idx_q == IDX_LAST) begin
          res_d.status = ST_EXHAUSTED;
          state_d      = S_DONE;
        end else begin
          acc_d = alu_res[ADDR_W-1:0];
          idx_d = idx_q + 1'b1;
        end
      end

      S_OFFSET: begin
        alu_a  = addr_q;
        alu_b  = base_i;
        alu_op = ALU_SUB;
        if (alu_res[ADDR_W]) begin
          // below base: contains misses, free is out of range
          if (cmd_q == CMD_FREE) begin
            res_d.status = ST_RANGE;
          end
          state_d = S_DONE;
        end else begin
          acc_d   = alu_res[ADDR_W-1:0];
          rem_d   = '0;
          cnt_d   = '0;
          state_d = S_DIV;
        end
      end

      S_DIV: begin
        // restoring divide, one quotient bit a cycle
        alu_a  = ADDR_W'(rem_shift);
        alu_b  = ADDR_W'(bsize_i);
        alu_op = ALU_SUB;
        if (alu_res[ADDR_W]) begin
          rem_d = rem_shift[BSIZE_W-1:0];
        end else begin
          rem_d = alu_res[BSIZE_W-1:0];
        end
        acc_d = {acc_q[ADDR_W-2:0], ~alu_res[ADDR_W]};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          state_d = S_CHECK;
        end
      end

      S_CHECK: begin
        if (cmd_q == CMD_CONTAINS) begin
          res_d.hit = in_pool;
        end else if (!in_pool) begin
          res_d.status = ST_RANGE;
        end else if (free_map_i[acc_q[IDX_W-1:0]]) begin
          res_d.status = ST_DOUBLE;
        end else begin
          map_op_d     = MAP_SET;
          map_idx_d    = acc_q[IDX_W-1:0];
          res_d.status = (rem_q != '0) ? ST_MISALIGNED : ST_OK;
        end
        state_d = S_DONE;
      end

      S_DONE: begin
        if (ack_i) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      map_op_q <= MAP_NONE;
    end else begin
      state_q  <= state_d;
      map_op_q <= map_op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    addr_q    <= addr_d;
    acc_q     <= acc_d;
    rem_q     <= rem_d;
    cnt_q     <= cnt_d;
    idx_q     <= idx_d;
    res_q     <= res_d;
    map_idx_q <= map_idx_d;
  end

endmodule

FILE: hw/rtl/bitmap_block_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_block_allocator
// Fixed-size block allocator over a pool of NUM_BLOCKS blocks with a
// free bitmap, an iterative sequencer and a registered result beat.
// ----------------------------------------------------------------------------
//
//  port group  | dir | beat contents
//  ------------+-----+------------------------------------------------------
//  s_axis_*    | in  | tuser: cmd; tdata: address
//  m_axis_*    | out | tdata: block_address, hit, status, all_free
//  cfg_*_i     | in  | write-only: 0 base_address, 1 block_size
//
//  Order of work, from the accepting edge to the edge that loads the output
//  register: allocate scans the bitmap one block a cycle from the lowest
//  index and stops at the first free block or after the last one. Free and
//  contains run a 32-step restoring divide on the shared add/sub unit; a
//  free or contains below base skips it, and an unused command goes straight
//  to the result. tready is back in the cycle after the load.
//  Reset: every block free, base_address 0, block_size 16.
//  Stalls: s_axis_tready is high only while the sequencer is idle; a result
//  waiting in the output register does not block the next accept, but the
//  following result waits until the output beat is taken.
//  A block_size of 0 behaves as 1.
// ----------------------------------------------------------------------------
module bitmap_block_allocator
  import bba_pkg::*;
#(
  parameter int unsigned NUM_BLOCKS = DEF_NUM_BLOCKS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // input stream
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [31:0]       s_axis_tdata,   // [31:0] address
  input  logic [1:0]        s_axis_tuser,   // [1:0] cmd
  // result stream
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [39:0]       m_axis_tdata,   // [31:0] block_address, [32] hit,
                                            // [35:33] status, [36] all_free
  // configuration writes
  input  logic              cfg_we_i,
  input  logic              cfg_index_i,
  input  logic [31:0]       cfg_data_i
);

  localparam int unsigned IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

  // config registers
  logic [ADDR_W-1:0]  base_q;
  logic [BSIZE_W-1:0] bsize_q;
  logic [BSIZE_W-1:0] bsize_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= BASE_RESET;
      bsize_q <= BSIZE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_BASE_ADDRESS: base_q  <= cfg_data_i;
        CFG_BLOCK_SIZE:   bsize_q <= cfg_data_i[BSIZE_W-1:0];
        default: ;
      endcase
    end
  end

  assign bsize_eff = (bsize_q == '0) ? BSIZE_W'(1) : bsize_q;

  // free bitmap, bit set while the block is free
  logic [NUM_BLOCKS-1:0] free_map_q, free_map_d;

  logic             seq_done;
  logic             seq_ack;
  result_t          seq_res;
  map_op_e          seq_map_op;
  logic [IDX_W-1:0] seq_map_idx;

  bba_seq #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .IDX_W      (IDX_W)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_cmd_i   (s_axis_tuser),
    .in_addr_i  (s_axis_tdata),
    .base_i     (base_q),
    .bsize_i    (bsize_eff),
    .free_map_i (free_map_q),
    .done_o     (seq_done),
    .ack_i      (seq_ack),
    .res_o      (seq_res),
    .map_op_o   (seq_map_op),
    .map_idx_o  (seq_map_idx)
  );

  // output register
  logic    out_valid_q, out_valid_d;
  result_t out_res_q;
  logic    out_all_free_q;

  // result moves out when the output slot is empty or being drained
  assign seq_ack = seq_done && (!out_valid_q || m_axis_tready);

  always_comb begin
    free_map_d = free_map_q;
    if (seq_ack) begin
      unique case (seq_map_op)
        MAP_SET: free_map_d[seq_map_idx] = 1'b1;
        MAP_CLR: free_map_d[seq_map_idx] = 1'b0;
        default: ;
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (seq_ack) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_map_q  <= '1;
      out_valid_q <= 1'b0;
    end else begin
      free_map_q  <= free_map_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq_ack) begin
      out_res_q      <= seq_res;
      out_all_free_q <= &free_map_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_all_free_q, out_res_q.status, out_res_q.hit,
                          out_res_q.block_address};

endmodule

FILE: tb/sv/bitmap_block_allocator_test.sv
// ----------------------------------------------------------------------------
// bitmap_block_allocator_test
// Self-checking bench for the bitmap block allocator: a queue-fed driver
// streams allocate, free, contains and unused-command beats, a shadow pool
// predicts every result beat, and a monitor compares them field by field
// under random stalls on both sides and a long output hold-off.
// ----------------------------------------------------------------------------
module bitmap_block_allocator_test;
  import bba_pkg::*;

  localparam int unsigned POOL_BLOCKS = DEF_NUM_BLOCKS;
  localparam logic [63:0] POOL_MASK   = {64{1'b1}} >> (64 - POOL_BLOCKS);
  // tuser value the block has no operation for
  localparam logic [1:0]  CMD_UNUSED  = 2'd3;
  localparam int          RUN_CYCLES  = 600000;

  // one input beat
  typedef struct {
    logic [1:0]  cmd;
    logic [31:0] addr;
  } pool_op_t;

  // shadow of the block's registers and bitmap
  typedef struct {
    logic [31:0]        base;
    logic [BSIZE_W-1:0] bsize;
    logic [63:0]        free_map;
  } pool_state_t;

  // one result beat, unpacked
  typedef struct {
    logic [31:0] block_address;
    logic        hit;
    status_e     status;
    logic        all_free;
  } pool_result_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = CMD_ALLOC;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        cfg_we_i      = 1'b0;
  logic        cfg_index_i   = CFG_BASE_ADDRESS;
  logic [31:0] cfg_data_i    = '0;

  pool_op_t     op_queue[$];          // beats waiting for the driver
  pool_result_t pending_results[$];   // predicted beats, oldest first
  pool_state_t  pool_now;             // shadow state, advanced on accept
  int           err_count    = 0;
  int           results_seen = 0;
  bit           quiet        = 1'b0;  // no random idling in the last phase
  int           src_gap      = 0;
  int           sink_gap     = 0;
  int           long_hold    = 0;
  bit           hold_done    = 1'b0;

  always #10 clk_i = ~clk_i;

  bitmap_block_allocator #(
    .NUM_BLOCKS(POOL_BLOCKS)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),   // [31:0] address
    .s_axis_tuser (s_axis_tuser),   // [1:0] cmd
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),   // [31:0] block_address, [32] hit,
                                    // [35:33] status, [36] all_free
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // --------------------------------------------------------------------------
  // Predictor: advances a pool state by one beat and returns the result.
  // --------------------------------------------------------------------------
  function automatic pool_result_t pool_step(inout pool_state_t st, input pool_op_t op);
    pool_result_t r;
    logic [31:0]  bs;
    logic [63:0]  off;
    logic [63:0]  idx;
    logic [63:0]  rem;
    logic [63:0]  pool_end;
    int           lowest;
    int           i;
    r = '{block_address: '0, hit: 1'b0, status: ST_OK, all_free: 1'b0};
    bs = (st.bsize == '0) ? 32'd1 : 32'(st.bsize);   // zero size acts as one
    lowest = -1;
    case (op.cmd)
      CMD_ALLOC: begin
        for (i = POOL_BLOCKS - 1; i >= 0; i--) begin
          if (st.free_map[i]) lowest = i;
        end
        if (lowest >= 0) begin
          st.free_map[lowest] = 1'b0;
          // block address wraps at 32 bits
          r.block_address = st.base + 32'(lowest) * bs;
          r.hit           = 1'b1;
        end else begin
          r.status = ST_EXHAUSTED;
        end
      end
      CMD_FREE: begin
        if (op.addr < st.base) begin
          r.status = ST_RANGE;
        end else begin
          off = 64'(op.addr) - 64'(st.base);
          idx = off / 64'(bs);
          rem = off % 64'(bs);
          // range check wins, then double free, then misalignment
          if (idx >= 64'(POOL_BLOCKS)) begin
            r.status = ST_RANGE;
          end else if (st.free_map[idx[5:0]]) begin
            r.status = ST_DOUBLE;
          end else begin
            st.free_map[idx[5:0]] = 1'b1;
            r.status = (rem != 0) ? ST_MISALIGNED : ST_OK;
          end
        end
      end
      CMD_CONTAINS: begin
        // pool end is taken without wrap
        pool_end = 64'(st.base) + 64'(POOL_BLOCKS) * 64'(bs);
        r.hit = (op.addr >= st.base) && (64'(op.addr) < pool_end);
      end
      default: begin
      end
    endcase
    st.free_map &= POOL_MASK;
    r.all_free = (st.free_map == POOL_MASK);
    return r;
  endfunction

  // Address near the interesting spots of the pool, or anywhere.
  function automatic logic [31:0] pick_probe(input pool_state_t st);
    logic [31:0] bs;
    logic [31:0] span;
    bs   = (st.bsize == '0) ? 32'd1 : 32'(st.bsize);
    span = POOL_BLOCKS * bs;
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return st.base + 32'($urandom_range(0, POOL_BLOCKS - 1)) * bs
                + 32'($urandom_range(0, bs - 1));
      2: return st.base - 32'($urandom_range(1, 64));
      3: return st.base + span - 32'($urandom_range(0, 1));
      4: return st.base + span + 32'($urandom_range(0, bs));
      default: return st.base;
    endcase
  endfunction

  function automatic void check_field(input string what, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      err_count++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Driver: offers queued beats, predicts each one as it is accepted.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : drive_beat
    logic     nxt_valid;
    pool_op_t nxt_op;
    nxt_valid = s_axis_tvalid;
    nxt_op    = '{cmd: s_axis_tuser, addr: s_axis_tdata};
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        pending_results.push_back(pool_step(pool_now, nxt_op));
        nxt_valid = 1'b0;
      end
      // a held beat stays put; only an empty slot may idle or load
      if (!nxt_valid) begin
        if (src_gap > 0) begin
          src_gap--;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
          src_gap = $urandom_range(0, 2);
        end else if (op_queue.size() > 0) begin
          nxt_op    = op_queue.pop_front();
          nxt_valid = 1'b1;
        end
      end
      s_axis_tvalid <= nxt_valid;
      s_axis_tuser  <= nxt_op.cmd;
      s_axis_tdata  <= nxt_op.addr;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks result beats and paces tready. One long hold-off early
  // in the run lets the block back up and drop s_axis_tready.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_beat
    pool_result_t want;
    logic         nxt_ready;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, got %0h",
                   $time, m_axis_tdata);
          err_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("block_address", want.block_address, m_axis_tdata[31:0]);
          check_field("hit", 32'(want.hit), 32'(m_axis_tdata[32]));
          check_field("status", 32'(want.status), 32'(m_axis_tdata[35:33]));
          check_field("all_free", 32'(want.all_free), 32'(m_axis_tdata[36]));
        end
      end
      nxt_ready = 1'b1;
      if (long_hold > 0) begin
        long_hold--;
        nxt_ready = 1'b0;
      end else if (!hold_done && results_seen >= 150) begin
        hold_done = 1'b1;
        long_hold = 300;
        nxt_ready = 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        nxt_ready = 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        sink_gap  = $urandom_range(0, 2);
        nxt_ready = 1'b0;
      end
      m_axis_tready <= nxt_ready;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic add_op(input logic [1:0] cmd, input logic [31:0] addr);
    op_queue.push_back('{cmd: cmd, addr: addr});
  endtask

  // Block is idle once every beat went out and every result came back.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (op_queue.size() != 0 || s_axis_tvalid || pending_results.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  // Writes both registers while idle; shadow follows immediately.
  task automatic set_pool(input logic [31:0] base, input logic [31:0] bsize);
    wait_drained();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_BASE_ADDRESS;
    cfg_data_i  <= base;
    pool_now.base = base;
    @(posedge clk_i);
    cfg_index_i <= CFG_BLOCK_SIZE;
    cfg_data_i  <= bsize;
    pool_now.bsize = bsize[BSIZE_W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Mostly well-formed traffic: frees aim at blocks that a private copy of
  // the pool says are allocated; the rest are probes and noise.
  task automatic queue_random_items(input int n, input int alloc_pct);
    pool_state_t sim;
    pool_op_t    op;
    int          used[$];
    int          roll;
    logic [31:0] bs;
    sim = pool_now;
    bs  = (sim.bsize == '0) ? 32'd1 : 32'(sim.bsize);
    repeat (n) begin
      used.delete();
      for (int i = 0; i < POOL_BLOCKS; i++) begin
        if (!sim.free_map[i]) used.push_back(i);
      end
      roll    = $urandom_range(0, 99);
      op.addr = $urandom;
      if (roll < alloc_pct) begin
        op.cmd = CMD_ALLOC;
      end else if (roll < alloc_pct + 35) begin
        op.cmd = CMD_FREE;
        if (used.size() > 0 && $urandom_range(0, 7) != 0) begin
          op.addr = sim.base + 32'(used[$urandom_range(0, used.size() - 1)]) * bs;
          if (bs > 1 && $urandom_range(0, 4) == 0)
            op.addr += 32'($urandom_range(1, bs - 1));
        end else begin
          op.addr = pick_probe(sim);
        end
      end else if (roll < 97) begin
        op.cmd = CMD_CONTAINS;
        if ($urandom_range(0, 1) == 1) op.addr = pick_probe(sim);
      end else begin
        op.cmd = CMD_UNUSED;
      end
      void'(pool_step(sim, op));
      op_queue.push_back(op);
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence of phases
  // --------------------------------------------------------------------------
  initial begin
    pool_now = '{base: BASE_RESET, bsize: BSIZE_RESET, free_map: POOL_MASK};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings: base 0, 16-byte blocks, pool ends at 0x400
    add_op(CMD_ALLOC,    32'hFFFF_FFFF);
    add_op(CMD_CONTAINS, 32'h0000_03FF);
    add_op(CMD_CONTAINS, 32'h0000_0400);
    add_op(CMD_FREE,     32'h0000_0000);
    add_op(CMD_FREE,     32'h0000_0000);   // double free
    add_op(CMD_UNUSED,   32'hFFFF_FFFF);

    // misaligned free, double free over misaligned, below base,
    // beyond pool over misaligned, contains bounds
    set_pool(32'h0000_1000, 32'd16);
    add_op(CMD_ALLOC,    32'h0);
    add_op(CMD_ALLOC,    32'h0);
    add_op(CMD_FREE,     32'h0000_1013);
    add_op(CMD_FREE,     32'h0000_1011);
    add_op(CMD_FREE,     32'h0000_0FFF);
    add_op(CMD_FREE,     32'h0000_1405);
    add_op(CMD_CONTAINS, 32'h0000_1000);
    add_op(CMD_CONTAINS, 32'h0000_13FF);
    add_op(CMD_CONTAINS, 32'h0000_1400);
    add_op(CMD_FREE,     32'h0000_1000);

    // pool at the top of memory: second block wraps, contains stops at 2^32
    set_pool(32'hFFFF_F000, 32'd65536);
    add_op(CMD_ALLOC,    32'h0);
    add_op(CMD_ALLOC,    32'h0);
    add_op(CMD_CONTAINS, 32'hFFFF_FFFF);
    add_op(CMD_CONTAINS, 32'h0000_F000);
    add_op(CMD_FREE,     32'h0000_F000);   // wrapped block sits below base
    add_op(CMD_FREE,     32'hFFFF_F000);

    // zero block size acts as one byte
    set_pool(32'h0000_0000, 32'd0);
    add_op(CMD_ALLOC,    32'h0);
    add_op(CMD_CONTAINS, 32'd63);
    add_op(CMD_CONTAINS, 32'd64);
    add_op(CMD_FREE,     32'd1);

    // random phases, alternating filling and draining the pool
    set_pool(32'h0000_0000, 32'd16);
    queue_random_items(147, 55);
    set_pool(32'hFFFF_FFFF, 32'd1);
    queue_random_items(147, 45);
    set_pool(32'h8000_0000, 32'd65536);
    queue_random_items(147, 60);
    set_pool($urandom, 32'd131071);
    queue_random_items(147, 10);
    set_pool($urandom & 32'hFFFF_FFF0, 32'($urandom_range(1, 4096)));
    queue_random_items(147, 60);
    set_pool(32'hFFFF_F000, 32'd65536);
    queue_random_items(147, 10);
    set_pool(32'h1234_5670, 32'd0);
    queue_random_items(147, 50);
    set_pool($urandom, 32'($urandom_range(1, 64)));
    queue_random_items(147, 15);
    set_pool($urandom, 32'($urandom_range(1, 65536)));
    quiet = 1'b1;
    queue_random_items(147, 45);

    // drain, then give any stray beat time to show up
    wait_drained();
    repeat (80) @(posedge clk_i);
    if (err_count == 0) begin
      $display("bitmap_block_allocator_test: done, clean");
    end else begin
      $display("bitmap_block_allocator_test: done, errors");
    end
    $finish;
  end

  // hang guard
  initial begin
    #(RUN_CYCLES * 20);
    $display("bitmap_block_allocator_test: done, errors");
    $finish;
  end

endmodule
